// ===== sv/serial_bit_table_poller_unit_defines.svh =====
// Assertion macros for the serial bit table poller unit.
`ifndef SERIAL_BIT_TABLE_POLLER_UNIT_DEFINES_SVH
`define SERIAL_BIT_TABLE_POLLER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define SBTP_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sbtp: same-cycle check failed");
`define SBTP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sbtp: next-cycle check failed");
`else
`define SBTP_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define SBTP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== sv/sbtp_pkg.sv =====
package sbtp_pkg;

	localparam int unsigned SW_TBL_W = 36;
	localparam logic [35:0] SW_TBL_RST = 36'd161;

	localparam logic [7:0] CMD_READ   = 8'hDD;
	localparam logic [7:0] CMD_WRITE0 = 8'hEE;
	localparam logic [7:0] CMD_WRITE1 = 8'hFF;

	localparam logic KIND_TX     = 1'b0;
	localparam logic KIND_REPORT = 1'b1;

	localparam logic REQ_TICK = 1'b0;
	localparam logic REQ_BYTE = 1'b1;

	typedef struct packed {
		logic       kind;
		logic [7:0] tx_byte;
		logic       tx_last;
		logic [6:0] sig_index;
		logic       sig_bit;
		logic       accepted;
	} res_t;

endpackage

// ===== sv/sbtp_out_buf.sv =====
module sbtp_out_buf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  logic             two,
	input  sbtp_pkg::res_t   first,
	input  sbtp_pkg::res_t   second,
	output logic             free,
	output logic             valid,
	input  logic             stall,
	output sbtp_pkg::res_t   res
);
	import sbtp_pkg::*;

	logic valid_q;
	logic has_next_q;
	res_t res_q;
	res_t next_q;
	logic take;

	assign take  = valid_q && !stall;
	assign free  = !valid_q || (take && !has_next_q);
	assign valid = valid_q;
	assign res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= 1'b0;
			has_next_q <= 1'b0;
		end else if (load) begin
			valid_q    <= 1'b1;
			has_next_q <= two;
		end else if (take) begin
			if (has_next_q) begin
				has_next_q <= 1'b0;
			end else begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q  <= first;
			next_q <= second;
		end else if (take && has_next_q) begin
			res_q <= next_q;
		end
	end

endmodule

// ===== sv/serial_bit_table_poller_unit.sv =====
// channel   | valid / stall          | payload
// request   | req_valid / req_stall  | req_type, rx_byte
// result    | res_valid / res_stall  | out_kind, tx_byte, tx_last, sig_index, sig_bit, accepted
// config    | cfg_we                 | cfg_wdata (switch table)
//
// A request is registered, then decoded into the result buffer.
// A timer tick yields two transmit bytes; a received byte yields one report.
// A new request is loaded as the last result leaves the buffer, unless stalled.
// Reset clears the pass state and the signal mirror; switch table resets to 161.
// res_stall holds the result buffer and backs up into req_stall.
module serial_bit_table_poller_unit #(
	parameter int unsigned NUM_SIGNALS  = 66,
	parameter int unsigned NUM_SWITCHES = 36
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [sbtp_pkg::SW_TBL_W-1:0]  cfg_wdata,
	input  logic                           req_valid,
	output logic                           req_stall,
	input  logic                           req_type,
	input  logic [7:0]                     rx_byte,
	output logic                           res_valid,
	input  logic                           res_stall,
	output logic                           out_kind,
	output logic [7:0]                     tx_byte,
	output logic                           tx_last,
	output logic [6:0]                     sig_index,
	output logic                           sig_bit,
	output logic                           accepted
);
	import sbtp_pkg::*;
`include "serial_bit_table_poller_unit_defines.svh"

	localparam logic [6:0] NSIG     = 7'(NUM_SIGNALS);
	localparam logic [6:0] LAST_ADR = 7'(NUM_SIGNALS - 1);
	localparam logic [6:0] NSW      = 7'(NUM_SWITCHES);
	localparam logic [6:0] TBL_LIM  = 7'(SW_TBL_W);

	logic [SW_TBL_W-1:0]    switch_table_q;
	logic [6:0]             next_address_q;
	logic                   write_pass_q;
	logic                   repeat_pending_q;
	logic                   reply_seen_q;
	logic [7:0]             last_command_q;
	logic [6:0]             last_address_q;
	logic [NUM_SIGNALS-1:0] mirror_q;

	logic       valid_s1;
	logic       req_type_s1;
	logic [7:0] rx_byte_s1;

	logic free;
	logic adv;
	logic two;
	res_t first;
	res_t second;
	res_t res;

	logic [6:0] rx_adr;
	logic       rx_ok;
	logic       resend;
	logic       sw_one;
	logic [7:0] new_cmd;

	assign adv       = valid_s1 && free;
	assign req_stall = valid_s1 && !free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || adv) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_type_s1 <= req_type;
			rx_byte_s1  <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			switch_table_q <= SW_TBL_RST;
		end else if (cfg_we) begin
			switch_table_q <= cfg_wdata;
		end
	end

	assign rx_adr = rx_byte_s1[6:0];
	assign rx_ok  = rx_adr < NSIG;
	assign resend = repeat_pending_q && !reply_seen_q;
	assign sw_one = (next_address_q < NSW) && (next_address_q < TBL_LIM)
		&& switch_table_q[next_address_q[5:0]];
	assign new_cmd = !write_pass_q ? CMD_READ : (sw_one ? CMD_WRITE1 : CMD_WRITE0);

	always_comb begin
		first  = '0;
		second = '0;
		two    = 1'b1;
		first.kind  = KIND_TX;
		second.kind = KIND_TX;
		second.tx_last = 1'b1;
		case (req_type_s1)
			REQ_BYTE: begin
				two              = 1'b0;
				first.kind       = KIND_REPORT;
				first.sig_index  = rx_adr;
				first.sig_bit    = rx_byte_s1[7];
				first.accepted   = rx_ok;
			end
			REQ_TICK: begin
				if (resend) begin
					first.tx_byte  = last_command_q;
					second.tx_byte = {1'b0, last_address_q};
				end else begin
					first.tx_byte  = new_cmd;
					second.tx_byte = {1'b0, next_address_q};
				end
			end
			default: begin
				two = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_address_q   <= '0;
			write_pass_q     <= 1'b0;
			repeat_pending_q <= 1'b0;
			reply_seen_q     <= 1'b0;
			last_command_q   <= '0;
			last_address_q   <= '0;
			mirror_q         <= '0;
		end else if (adv) begin
			if (req_type_s1 == REQ_BYTE) begin
				reply_seen_q <= 1'b1;
				if (rx_ok) begin
					mirror_q[rx_adr] <= rx_byte_s1[7];
				end
			end else if (!resend) begin
				if (!write_pass_q) begin
					repeat_pending_q <= 1'b1;
					reply_seen_q     <= 1'b0;
				end else begin
					repeat_pending_q <= 1'b0;
				end
				last_command_q <= new_cmd;
				last_address_q <= next_address_q;
				if (next_address_q < LAST_ADR) begin
					next_address_q <= next_address_q + 7'd1;
				end else begin
					next_address_q <= '0;
					write_pass_q   <= !write_pass_q;
				end
			end
		end
	end

	sbtp_out_buf u_out_buf (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (adv),
		.two    (two),
		.first  (first),
		.second (second),
		.free   (free),
		.valid  (res_valid),
		.stall  (res_stall),
		.res    (res)
	);

	assign out_kind  = res.kind;
	assign tx_byte   = res.tx_byte;
	assign tx_last   = res.tx_last;
	assign sig_index = res.sig_index;
	assign sig_bit   = res.sig_bit;
	assign accepted  = res.accepted;

	`SBTP_ASSERT_SAME(a_mirror_match, clk, arst_n, res_valid && accepted, mirror_q[sig_index] == sig_bit)
	`SBTP_ASSERT_SAME(a_accept_range, clk, arst_n, res_valid && accepted, (out_kind == KIND_REPORT) && (sig_index < NSIG))
	`SBTP_ASSERT_NEXT(a_addr_follows, clk, arst_n, res_valid && !res_stall && (out_kind == KIND_TX) && !tx_last, res_valid && (out_kind == KIND_TX) && tx_last)

endmodule
